/* sv/fbfla_pkg.sv */
// Shared types for the fixed-block free-list allocator.
// Holds the command word between front and engine and the result word; no dependencies.
`timescale 1ns / 1ps

package fbfla_pkg;

  // Command class decided by the front part
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_DROP  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FREED   = 2'd2
  } status_e;

  localparam int unsigned FieldW = 4;

  typedef struct packed {
    op_e               op;
    logic [FieldW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] granted_index;
  } res_t;

endpackage

/* sv/fixed_block_free_list_allocator_core.sv */
// Top level of the fixed-block free-list allocator.
// Depends on fbfla_pkg, fbfla_front, fbfla_engine and fbfla_res_queue.
`timescale 1ns / 1ps

// Usage
//   Request side looks like a queue: drive command_i/block_index_i and raise
//   push; the word is taken at a clock edge where push is high and full is low.
//   command_i 0 allocates a block, 1 frees block_index_i.
//   Result side looks like a queue too: while empty is low, status_o and
//   granted_index_o show the oldest result; raise pop to take it.
//   Exactly one result word comes back per request word, in order.
// Timing
//   A free, and an allocate on an empty pool, is executed in the run state;
//   a granted allocate goes on to the read state (the link of the head block
//   is read from the link memory through a registered port). A free can be
//   taken at one per cycle while the result queue has room; a granted
//   allocate holds the engine in the read state before the next command.
// Reset
//   After reset the engine walks the link memory once, one entry a cycle,
//   chaining block i to block i+1; full is held high throughout the walk.
//   The head starts at block 0.
// Stalls
//   When pop stays low, the result queue fills, the engine holds, the command
//   queue fills and full rises; no word is dropped.

module fixed_block_free_list_allocator_core #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [3:0] block_index_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status_o,
  output logic [3:0] granted_index_o
);

  logic            front_full;
  logic            init_busy;
  logic            cmd_valid;
  logic            cmd_take;
  fbfla_pkg::cmd_t cmd;
  logic            res_push;
  logic            res_full;
  fbfla_pkg::res_t eng_res;
  fbfla_pkg::res_t out_res;

  // Hold off requests while the link memory is being chained after reset
  assign full = front_full || init_busy;

  fbfla_front #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push && !full),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .full_o        (front_full),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  fbfla_engine #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (eng_res),
    .init_busy_o (init_busy)
  );

  fbfla_res_queue u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (eng_res),
    .res_full_o (res_full),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (out_res)
  );

  // Drive the result word fields
  assign status_o        = out_res.status;
  assign granted_index_o = out_res.granted_index;

endmodule

/* sv/fbfla_front.sv */
// Front part of the allocator: classifies incoming words and queues them.
// Depends on fbfla_pkg for the command word type.
`timescale 1ns / 1ps

module fbfla_front #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          command_i,
  input  logic [fbfla_pkg::FieldW-1:0]  block_index_i,
  output logic                          full_o,
  output logic                          cmd_valid_o,
  output fbfla_pkg::cmd_t               cmd_o,
  input  logic                          cmd_take_i
);

  localparam logic CmdFree = 1'b1;

  fbfla_pkg::cmd_t entry_q [2];
  fbfla_pkg::cmd_t new_cmd;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  // Classify: allocate, free, or free of a block outside the pool
  always_comb begin
    new_cmd.idx = block_index_i;
    if (command_i != CmdFree) begin
      new_cmd.op = fbfla_pkg::OP_ALLOC;
    end else if (32'(block_index_i) < POOL_DEPTH) begin
      new_cmd.op = fbfla_pkg::OP_FREE;
    end else begin
      new_cmd.op = fbfla_pkg::OP_DROP;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ cmd_take_i;
    unique case ({push_i, cmd_take_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

/* sv/fbfla_engine.sv */
// Back part of the allocator: link memory, free-list head and the sequencer.
// Depends on fbfla_pkg for the command and result word types.
`timescale 1ns / 1ps

module fbfla_engine #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  fbfla_pkg::cmd_t cmd_i,
  output logic            cmd_take_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output fbfla_pkg::res_t res_o,
  output logic            init_busy_o
);

  localparam int unsigned IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NullLink = LW'(POOL_DEPTH);
  localparam logic [IW-1:0] LastIdx  = IW'(POOL_DEPTH - 1);

  typedef enum logic [2:0] {
    S_INIT = 3'b001,
    S_RUN  = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [LW-1:0]     head_q, head_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [LW-1:0]     grant_q, grant_d;
  logic [LW-1:0]     link_mem [POOL_DEPTH];
  logic [LW-1:0]     rd_q;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_wa;
  logic [LW-1:0]     mem_wd;
  logic [IW+fbfla_pkg::FieldW-1:0] idx_ext;
  logic [LW+fbfla_pkg::FieldW-1:0] grant_ext;

  assign idx_ext     = {{IW{1'b0}}, cmd_i.idx};
  assign grant_ext   = {{fbfla_pkg::FieldW{1'b0}}, grant_q};
  assign init_busy_o = (state_q == S_INIT);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    grant_d    = grant_q;
    mem_we     = 1'b0;
    mem_wa     = idx_ext[IW-1:0];
    mem_wd     = head_q;
    mem_re     = 1'b0;
    cmd_take_o = 1'b0;
    res_push_o = 1'b0;
    res_o.status        = fbfla_pkg::ST_FREED;
    res_o.granted_index = '0;
    unique case (state_q)
      S_INIT: begin
        // Chain each block to the next; the last one links to null
        mem_we = 1'b1;
        mem_wa = cnt_q;
        mem_wd = LW'(cnt_q) + LW'(1);
        if (cnt_q == LastIdx) begin
          state_d = S_RUN;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      S_RUN: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_take_o = 1'b1;
          unique case (cmd_i.op)
            fbfla_pkg::OP_FREE: begin
              mem_we     = 1'b1;
              head_d     = LW'(idx_ext[IW-1:0]);
              res_push_o = 1'b1;
            end
            fbfla_pkg::OP_ALLOC: begin
              if (head_q == NullLink) begin
                res_push_o   = 1'b1;
                res_o.status = fbfla_pkg::ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                grant_d = head_q;
                state_d = S_READ;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // Link of the granted block becomes the new head
        if (!res_full_i) begin
          head_d              = rd_q;
          res_push_o          = 1'b1;
          res_o.status        = fbfla_pkg::ST_GRANTED;
          res_o.granted_index = grant_ext[fbfla_pkg::FieldW-1:0];
          state_d             = S_RUN;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grant_q <= grant_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= link_mem[head_q[IW-1:0]];
    end
  end

  a_head_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NullLink)
    else $error("free-list head beyond null link");

  a_read_valid_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (grant_q != NullLink))
    else $error("link read for a null head");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_grant_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.status == fbfla_pkg::ST_GRANTED) |-> (state_q == S_READ))
    else $error("grant issued outside the link read step");

  a_take_when_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> (cmd_valid_i && state_q == S_RUN))
    else $error("command taken while not running");

endmodule

/* sv/fbfla_res_queue.sv */
// Result queue of the allocator: two-entry buffer toward the consumer.
// Depends on fbfla_pkg for the result word type.
`timescale 1ns / 1ps

module fbfla_res_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_push_i,
  input  fbfla_pkg::res_t res_i,
  output logic            res_full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output fbfla_pkg::res_t res_o
);

  fbfla_pkg::res_t entry_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_pop;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign res_o      = entry_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    unique case ({res_push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ res_push_i;
      rd_ptr_q <= rd_ptr_q ^ do_pop;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

/* tb/sv/fixed_block_free_list_allocator_core_tb.sv */
// Self-checking bench for fixed_block_free_list_allocator_core: a directed table, then random
// alloc/free traffic checked against an in-bench model of the free list.
// Depends on fbfla_pkg and the allocator RTL.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_core_tb;

  localparam int unsigned POOL_DEPTH = 16;
  localparam logic [4:0] NULL_LINK = 5'(POOL_DEPTH);

  // request codes on command_i
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int OPENING_ROWS = 23;
  localparam int CLOSING_ROWS = 4;
  localparam int RANDOM_WORDS = 680;
  localparam int CALM_WORDS   = 100;  // final random words with no idling on either side
  localparam int STEADY_WORDS = 60;   // first random words pushed back to back
  localparam int HOLD_CYCLES  = 90;   // one long pop hold-off to back the block up
  localparam int QUIET_LIMIT  = 400;  // cycles with no word moving before giving up
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic                cmd;
    logic [3:0]          idx;
    bit                  typed;  // expected word written in the row, else the model decides
    fbfla_pkg::status_e  st;
    logic [3:0]          gi;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       command_i;
  logic [3:0] block_index_i;
  logic       empty;
  logic       pop;
  logic [1:0] status_o;
  logic [3:0] granted_index_o;

  // free-list model state
  logic [4:0] next_free [POOL_DEPTH];
  logic [4:0] free_head;
  bit         block_in_use [POOL_DEPTH];

  fbfla_pkg::res_t owed_results [$];
  int   errors = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;

  // From reset: grant 0 and 1, return 0 and take it back, drain the pool, hit empty twice
  // (once with all index bits set, which allocate ignores), then free at the top index and
  // let the model follow a free/alloc pair.
  stim_row_t opening_rows [OPENING_ROWS] = '{
    '{CMD_ALLOC, 4'hF, 1'b1, fbfla_pkg::ST_GRANTED, 4'd0},
    '{CMD_ALLOC, 4'h0, 1'b1, fbfla_pkg::ST_GRANTED, 4'd1},
    '{CMD_FREE,  4'h0, 1'b1, fbfla_pkg::ST_FREED,   4'd0},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd0},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd2},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd3},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd4},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd5},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd6},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd7},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd8},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd9},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd10},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd11},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd12},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd13},
    '{CMD_ALLOC, 4'h5, 1'b1, fbfla_pkg::ST_GRANTED, 4'd14},
    '{CMD_ALLOC, 4'hA, 1'b1, fbfla_pkg::ST_GRANTED, 4'd15},
    '{CMD_ALLOC, 4'hF, 1'b1, fbfla_pkg::ST_EMPTY,   4'd0},
    '{CMD_ALLOC, 4'h0, 1'b1, fbfla_pkg::ST_EMPTY,   4'd0},
    '{CMD_FREE,  4'hF, 1'b1, fbfla_pkg::ST_FREED,   4'd0},
    '{CMD_FREE,  4'h9, 1'b0, fbfla_pkg::ST_FREED,   4'd0},
    '{CMD_ALLOC, 4'h3, 1'b0, fbfla_pkg::ST_GRANTED, 4'd0}
  };

  // Double free of block 5: the second free links 5 to itself, so every later allocate
  // hands out 5 again. The loop never breaks, which is why these rows close the run.
  stim_row_t closing_rows [CLOSING_ROWS] = '{
    '{CMD_FREE,  4'h5, 1'b1, fbfla_pkg::ST_FREED,   4'd0},
    '{CMD_FREE,  4'h5, 1'b1, fbfla_pkg::ST_FREED,   4'd0},
    '{CMD_ALLOC, 4'h0, 1'b1, fbfla_pkg::ST_GRANTED, 4'd5},
    '{CMD_ALLOC, 4'hC, 1'b1, fbfla_pkg::ST_GRANTED, 4'd5}
  };

  fixed_block_free_list_allocator_core #(
    .POOL_DEPTH(POOL_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .block_index_i  (block_index_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .granted_index_o(granted_index_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Apply one request to the model: pop the head on allocate, push the index on free.
  function automatic fbfla_pkg::res_t advance_free_list(input logic cmd, input logic [3:0] idx);
    fbfla_pkg::res_t r;
    r.granted_index = '0;
    if (cmd == CMD_ALLOC) begin
      if (free_head < NULL_LINK) begin
        r.status        = fbfla_pkg::ST_GRANTED;
        r.granted_index = free_head[3:0];
        free_head       = next_free[free_head[3:0]];
        if (free_head > NULL_LINK) free_head = NULL_LINK;
      end else begin
        r.status = fbfla_pkg::ST_EMPTY;
      end
    end else begin
      if (idx < POOL_DEPTH) begin
        next_free[idx] = free_head;
        free_head      = {1'b0, idx};
      end
      r.status = fbfla_pkg::ST_FREED;
    end
    return r;
  endfunction

  // Offer one request word, hold it until taken, then record what must come back.
  // Optionally drop push for a random burst afterwards.
  task automatic send_word(input logic cmd, input logic [3:0] idx, input bit typed,
                           input fbfla_pkg::res_t want, input bit may_idle);
    fbfla_pkg::res_t predicted;
    push          <= 1'b1;
    command_i     <= cmd;
    block_index_i <= idx;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = advance_free_list(cmd, idx);
    owed_results.insert(owed_results.size(), typed ? want : predicted);
    if (predicted.status == fbfla_pkg::ST_GRANTED) block_in_use[predicted.granted_index] = 1'b1;
    else if (cmd == CMD_FREE) block_in_use[idx] = 1'b0;
    if (may_idle && !calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Main request process: reset, opening table, random traffic, closing table, drain.
  initial begin : request_side
    int   alloc_pct;
    int   held_cnt;
    int   pick;
    int   victim;
    fbfla_pkg::res_t want;
    push          <= 1'b0;
    command_i     <= CMD_ALLOC;
    block_index_i <= 4'd0;
    rst_ni        <= 1'b0;
    for (int b = 0; b < POOL_DEPTH; b++) begin
      next_free[b]    = 5'(b + 1);
      block_in_use[b] = 1'b0;
    end
    free_head = 5'd0;
    alloc_pct = 50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[r]) begin
      want.status        = opening_rows[r].st;
      want.granted_index = opening_rows[r].gi;
      send_word(opening_rows[r].cmd, opening_rows[r].idx, opening_rows[r].typed, want, 1'b1);
    end

    // Only well-formed frees here: a block is returned only while the client holds it,
    // so the list never loops and the pool can run dry again. Allocate bias changes in
    // phases to swing between an empty pool and a nearly full one.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       alloc_pct = 20;
          1:       alloc_pct = 50;
          2:       alloc_pct = 80;
          default: alloc_pct = 95;
        endcase
      end
      if (n >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      held_cnt = 0;
      foreach (block_in_use[b]) if (block_in_use[b]) held_cnt++;
      if (held_cnt == 0 || $urandom_range(1, 100) <= alloc_pct) begin
        send_word(CMD_ALLOC, 4'($urandom), 1'b0, '0, n >= STEADY_WORDS);
      end else begin
        pick   = $urandom_range(0, held_cnt - 1);
        victim = 0;
        for (int b = 0; b < POOL_DEPTH; b++) begin
          if (block_in_use[b]) begin
            if (pick == 0) victim = b;
            pick--;
          end
        end
        send_word(CMD_FREE, 4'(victim), 1'b0, '0, n >= STEADY_WORDS);
      end
    end

    foreach (closing_rows[r]) begin
      want.status        = closing_rows[r].st;
      want.granted_index = closing_rows[r].gi;
      send_word(closing_rows[r].cmd, closing_rows[r].idx, closing_rows[r].typed, want, 1'b0);
    end
    push <= 1'b0;

    // Wait out every owed word, then a few more cycles to catch strays.
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Pop control: random stall bursts, plus one long hold-off once the opening words are
  // back, so the result queue and then the request side fill and full rises.
  initial begin : pop_side
    int gap;
    int taken;
    bit squeezed;
    gap      = 0;
    taken    = 0;
    squeezed = 1'b0;
    pop     <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) taken++;
      if (!squeezed && taken >= OPENING_ROWS) begin
        squeezed = 1'b1;
        gap      = HOLD_CYCLES;
      end
      if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(0, 16);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compare each popped word with the oldest owed one.
  always @(posedge clk_i) begin : result_check
    fbfla_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (owed_results.size() == 0) begin
        flag_error($sformatf("unexpected word: status %0d index %0d",
                             status_o, granted_index_o));
      end else begin
        want = owed_results.pop_front();
        if (status_o !== want.status)
          flag_error($sformatf("status got %0d want %0d", status_o, want.status));
        if (granted_index_o !== want.granted_index)
          flag_error($sformatf("granted_index got %0d want %0d",
                               granted_index_o, want.granted_index));
      end
    end
  end

  // Hang detection: give up when no word moves on either side for too long.
  always @(posedge clk_i) begin : stall_watch
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
